@@ rtl/nkc_pkg.sv @@
// Package for the nucleotide k-mer counter.
// Holds field widths, mode and command codes, the command struct and base decode.
// No dependencies.
package nkc_pkg;

    localparam int DEF_MAX_ORDER  = 5;
    localparam int DEF_COUNT_BITS = 32;

    localparam int CHAR_W      = 8;
    localparam int IDX_W       = 12;
    localparam int COUNT_OUT_W = 32;
    localparam int ORDER_W     = 3;
    localparam int MODE_W      = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 48;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd2;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_T = 2'd1;
    localparam logic [1:0] BASE_C = 2'd2;
    localparam logic [1:0] BASE_G = 2'd3;

    typedef enum logic [MODE_W-1:0] {
        MODE_BASE     = 2'd0,
        MODE_EOR      = 2'd1,
        MODE_RD_FULL  = 2'd2,
        MODE_RD_LOWER = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CMD_COUNT      = 2'd0,
        CMD_TAIL       = 2'd1,
        CMD_READ_FULL  = 2'd2,
        CMD_READ_LOWER = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      idx_ok;
    } cmd_ctrl_t;

    // {valid, code}
    function automatic logic [2:0] base_decode(input logic [CHAR_W-1:0] ch);
        logic [2:0] res;
        unique case (ch)
            CHAR_A:  res = {1'b1, BASE_A};
            CHAR_T:  res = {1'b1, BASE_T};
            CHAR_C:  res = {1'b1, BASE_C};
            CHAR_G:  res = {1'b1, BASE_G};
            default: res = 3'b000;
        endcase
        return res;
    endfunction

endpackage

@@ rtl/nkc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
// No dependencies.
module nkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/nkc_front.sv @@
// Front end: config register, base decode, rolling window and command build.
// Depends on nkc_pkg.
module nkc_front import nkc_pkg::*; #(
    parameter int MAX_ORDER = DEF_MAX_ORDER,
    parameter int FW        = 2 * (MAX_ORDER + 1),
    parameter int LA        = (MAX_ORDER == 0) ? 1 : 2 * MAX_ORDER
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ORDER_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [MODE_W-1:0]  in_mode,
    input  logic [CHAR_W-1:0]  in_char,
    input  logic [IDX_W-1:0]   in_idx,
    input  logic               clr_busy,
    input  logic               q_full,
    output logic               push,
    output cmd_ctrl_t          push_ctrl,
    output logic [FW-1:0]      push_faddr,
    output logic [LA-1:0]      push_laddr,
    output logic [IDX_W-1:0]   push_idx
);

    localparam int LW = 2 * MAX_ORDER;
    localparam int SW = $clog2(MAX_ORDER + 2);

    logic [ORDER_W-1:0] order_reg;
    logic [FW-1:0]      win_reg;
    logic [SW-1:0]      seen_reg;

    logic               accept;
    logic [2:0]         dec;
    logic [SW-1:0]      ord;
    logic [FW+1:0]      shifted;
    logic [FW-1:0]      win_next;
    logic [SW-1:0]      seen_next;
    logic [FW-1:0]      kmask;
    logic [FW-1:0]      tmask;
    logic [FW-1:0]      kfull;
    logic [FW-1:0]      tail;
    logic [FW+LA-1:0]   klow_ext;
    logic [FW+LA-1:0]   tail_ext;
    logic [IDX_W+FW-1:0] idx_ext_f;
    logic [IDX_W+LA-1:0] idx_ext_l;
    logic               full_ok;
    logic               lower_ok;
    logic               push_v;

    assign cfg_ready = 1'b1;
    assign in_ready  = !clr_busy && !q_full;
    assign accept    = in_valid && in_ready;

    assign dec      = base_decode(in_char);
    assign ord      = (int'(order_reg) > MAX_ORDER) ? SW'(MAX_ORDER) : SW'(order_reg);
    assign shifted  = {win_reg, dec[1:0]};
    assign win_next = shifted[FW-1:0];
    assign seen_next = (int'(seen_reg) < MAX_ORDER + 1) ? seen_reg + 1'b1 : seen_reg;

    always_comb
    begin
        for (int i = 0; i < FW; i++)
        begin
            kmask[i] = (i < 2 * (int'(ord) + 1));
            tmask[i] = (i < 2 * int'(ord));
        end
    end

    assign kfull     = win_next & kmask;
    assign tail      = win_reg & tmask;
    assign klow_ext  = (FW+LA)'(kfull >> 2);
    assign tail_ext  = (FW+LA)'(tail);
    assign idx_ext_f = (IDX_W+FW)'(in_idx);
    assign idx_ext_l = (IDX_W+LA)'(in_idx);
    assign full_ok   = (idx_ext_f >> FW) == '0;
    assign lower_ok  = (LW == 0) ? (in_idx == '0) : ((idx_ext_l >> LA) == '0);
    assign push_idx  = in_idx;

    always_comb
    begin
        push_v           = 1'b0;
        push_ctrl.kind   = CMD_COUNT;
        push_ctrl.idx_ok = 1'b1;
        push_faddr       = kfull;
        push_laddr       = klow_ext[LA-1:0];
        unique case (mode_t'(in_mode))
            MODE_BASE:
            begin
                push_v = dec[2] && (int'(seen_next) >= int'(ord) + 1);
            end
            MODE_EOR:
            begin
                push_v         = int'(seen_reg) >= int'(ord);
                push_ctrl.kind = CMD_TAIL;
                push_laddr     = tail_ext[LA-1:0];
            end
            MODE_RD_FULL:
            begin
                push_v           = 1'b1;
                push_ctrl.kind   = CMD_READ_FULL;
                push_ctrl.idx_ok = full_ok;
                push_faddr       = idx_ext_f[FW-1:0];
            end
            MODE_RD_LOWER:
            begin
                push_v           = 1'b1;
                push_ctrl.kind   = CMD_READ_LOWER;
                push_ctrl.idx_ok = lower_ok;
                push_laddr       = idx_ext_l[LA-1:0];
            end
            default:
            begin
                push_v = 1'b0;
            end
        endcase
    end

    assign push = accept && push_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
            win_reg   <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                order_reg <= cfg_data;
            end
            if (accept)
            begin
                if (in_mode == MODE_BASE && dec[2])
                begin
                    win_reg  <= win_next;
                    seen_reg <= seen_next;
                end
                else if (in_mode == MODE_EOR)
                begin
                    win_reg  <= '0;
                    seen_reg <= '0;
                end
            end
        end
    end

endmodule

@@ rtl/nkc_queue.sv @@
// Short command FIFO between front and back ends.
// Depends on nkc_pkg.
module nkc_queue import nkc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign full     = int'(count_reg) == DEPTH;
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/nkc_back.sv @@
// Back end: count RAMs, clearing pass, read-modify-write with forwarding,
// and a two-entry result buffer. Depends on nkc_pkg and nkc_ram.
module nkc_back import nkc_pkg::*; #(
    parameter int MAX_ORDER  = DEF_MAX_ORDER,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int FW         = 2 * (MAX_ORDER + 1),
    parameter int LA         = (MAX_ORDER == 0) ? 1 : 2 * MAX_ORDER
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  cmd_ctrl_t              q_ctrl,
    input  logic [FW-1:0]          q_faddr,
    input  logic [LA-1:0]          q_laddr,
    input  logic [IDX_W-1:0]       q_idx,
    output logic                   q_pop,
    output logic                   clr_busy,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [IDX_W-1:0]       out_idx,
    output logic [COUNT_OUT_W-1:0] out_count
);

    localparam int CW = COUNT_BITS;

    logic                   clr_busy_reg;
    logic [FW-1:0]          clr_addr_reg;

    logic                   b_valid_reg;
    cmd_ctrl_t              b_ctrl_reg;
    logic [FW-1:0]          b_faddr_reg;
    logic [LA-1:0]          b_laddr_reg;
    logic [IDX_W-1:0]       b_idx_reg;

    logic                   fwd_f_v_reg;
    logic [FW-1:0]          fwd_f_addr_reg;
    logic [CW-1:0]          fwd_f_data_reg;
    logic                   fwd_l_v_reg;
    logic [LA-1:0]          fwd_l_addr_reg;
    logic [CW-1:0]          fwd_l_data_reg;

    logic [IDX_W-1:0]       ob_idx_reg [2];
    logic [COUNT_OUT_W-1:0] ob_val_reg [2];
    logic                   o_wr_reg;
    logic                   o_rd_reg;
    logic [1:0]             o_cnt_reg;

    logic                   head_read;
    logic                   b_read;
    logic                   o_pop;
    logic                   credit_ok;
    logic                   issue;
    logic [CW-1:0]          f_rdata;
    logic [CW-1:0]          l_rdata;
    logic [CW-1:0]          f_cur;
    logic [CW-1:0]          l_cur;
    logic [CW-1:0]          f_inc;
    logic [CW-1:0]          l_inc;
    logic                   f_we_b;
    logic                   l_we_b;
    logic [CW-1:0]          rd_val;
    logic [CW+COUNT_OUT_W-1:0] rd_ext;
    logic [COUNT_OUT_W-1:0] rd_clip;

    assign clr_busy  = clr_busy_reg;
    assign head_read = (q_ctrl.kind == CMD_READ_FULL) || (q_ctrl.kind == CMD_READ_LOWER);
    assign b_read    = b_valid_reg &&
                       ((b_ctrl_reg.kind == CMD_READ_FULL) || (b_ctrl_reg.kind == CMD_READ_LOWER));
    assign o_pop     = out_valid && out_ready;
    // result buffer occupancy in the next cycle must leave room for a new read
    assign credit_ok = (int'(o_cnt_reg) + int'(b_read) - int'(o_pop)) <= 1;
    assign issue     = !q_empty && !clr_busy_reg && (!head_read || credit_ok);
    assign q_pop     = issue;

    assign f_cur  = (fwd_f_v_reg && fwd_f_addr_reg == b_faddr_reg) ? fwd_f_data_reg : f_rdata;
    assign l_cur  = (fwd_l_v_reg && fwd_l_addr_reg == b_laddr_reg) ? fwd_l_data_reg : l_rdata;
    assign f_inc  = (&f_cur) ? f_cur : f_cur + 1'b1;
    assign l_inc  = (&l_cur) ? l_cur : l_cur + 1'b1;
    assign f_we_b = b_valid_reg && (b_ctrl_reg.kind == CMD_COUNT);
    assign l_we_b = b_valid_reg &&
                    ((b_ctrl_reg.kind == CMD_COUNT) || (b_ctrl_reg.kind == CMD_TAIL));

    always_comb
    begin
        rd_val = '0;
        if (b_ctrl_reg.idx_ok)
        begin
            rd_val = (b_ctrl_reg.kind == CMD_READ_FULL) ? f_cur : l_cur;
        end
    end

    assign rd_ext  = (CW+COUNT_OUT_W)'(rd_val);
    assign rd_clip = ((rd_ext >> COUNT_OUT_W) != '0) ? '1 : rd_ext[COUNT_OUT_W-1:0];

    nkc_ram #(
        .WIDTH (CW),
        .DEPTH (1 << FW)
    ) u_full_ram (
        .clk   (clk),
        .we    (clr_busy_reg || f_we_b),
        .waddr (clr_busy_reg ? clr_addr_reg : b_faddr_reg),
        .wdata (clr_busy_reg ? '0 : f_inc),
        .re    (issue),
        .raddr (q_faddr),
        .rdata (f_rdata)
    );

    nkc_ram #(
        .WIDTH (CW),
        .DEPTH (1 << LA)
    ) u_lower_ram (
        .clk   (clk),
        .we    (clr_busy_reg || l_we_b),
        .waddr (clr_busy_reg ? clr_addr_reg[LA-1:0] : b_laddr_reg),
        .wdata (clr_busy_reg ? '0 : l_inc),
        .re    (issue),
        .raddr (q_laddr),
        .rdata (l_rdata)
    );

    assign out_valid = o_cnt_reg != '0;
    assign out_idx   = ob_idx_reg[o_rd_reg];
    assign out_count = ob_val_reg[o_rd_reg];

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_ctrl_reg  <= q_ctrl;
            b_faddr_reg <= q_faddr;
            b_laddr_reg <= q_laddr;
            b_idx_reg   <= q_idx;
        end
        if (f_we_b)
        begin
            fwd_f_addr_reg <= b_faddr_reg;
            fwd_f_data_reg <= f_inc;
        end
        if (l_we_b)
        begin
            fwd_l_addr_reg <= b_laddr_reg;
            fwd_l_data_reg <= l_inc;
        end
        if (b_read)
        begin
            ob_idx_reg[o_wr_reg] <= b_idx_reg;
            ob_val_reg[o_wr_reg] <= rd_clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            b_valid_reg  <= 1'b0;
            fwd_f_v_reg  <= 1'b0;
            fwd_l_v_reg  <= 1'b0;
            o_wr_reg     <= 1'b0;
            o_rd_reg     <= 1'b0;
            o_cnt_reg    <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            b_valid_reg <= issue;
            fwd_f_v_reg <= f_we_b;
            fwd_l_v_reg <= l_we_b;
            if (b_read)
            begin
                o_wr_reg <= !o_wr_reg;
            end
            if (o_pop)
            begin
                o_rd_reg <= !o_rd_reg;
            end
            if (b_read && !o_pop)
            begin
                o_cnt_reg <= o_cnt_reg + 1'b1;
            end
            else if (o_pop && !b_read)
            begin
                o_cnt_reg <= o_cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/nucleotide_kmer_counter.sv @@
// Top level of the nucleotide k-mer counter: front end, command queue, back end.
// Depends on nkc_pkg, nkc_front, nkc_queue, nkc_back.
//
//  channel  dir  handshake            payload
//  cfg      in   cfg_valid/cfg_ready  cfg_data[2:0] = model_order
//  s        in   s_tvalid/s_tready    tuser = mode; tdata = character, table_index
//  m        out  m_tvalid/m_tready    tdata = read_index, count_value
//
// One item per cycle while s_tready is high; m_tvalid for a read rises once the item has passed
// the command queue, the back-end stage register and the result buffer. Count updates are
// read-modify-write with forwarding of the last write. After reset a clearing pass over all
// 4^(MAX_ORDER+1) full-table addresses (4096 by default) zeroes both tables; s_tready stays
// low until it ends. After that s_tready drops only while the four-entry command queue is full;
// the two-entry result buffer lets m_tready stall without losing the read that is in flight.
module nucleotide_kmer_counter import nkc_pkg::*; #(
    parameter int MAX_ORDER  = DEF_MAX_ORDER,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ORDER_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] character, [19:8] table_index
    input  logic [MODE_W-1:0]    s_tuser,   // [1:0] mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [11:0] read_index, [43:12] count_value
);

    localparam int FW = 2 * (MAX_ORDER + 1);
    localparam int LA = (MAX_ORDER == 0) ? 1 : 2 * MAX_ORDER;
    localparam int CTRL_W = $bits(cmd_ctrl_t);
    localparam int QW = CTRL_W + FW + LA + IDX_W;

    logic                   clr_busy;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_push;
    logic                   q_pop;
    cmd_ctrl_t              push_ctrl;
    logic [FW-1:0]          push_faddr;
    logic [LA-1:0]          push_laddr;
    logic [IDX_W-1:0]       push_idx;
    logic [QW-1:0]          q_wdata;
    logic [QW-1:0]          q_rdata;
    cmd_ctrl_t              head_ctrl;
    logic [IDX_W-1:0]       out_idx;
    logic [COUNT_OUT_W-1:0] out_count;

    nkc_front #(
        .MAX_ORDER (MAX_ORDER),
        .FW        (FW),
        .LA        (LA)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_char    (s_tdata[7:0]),
        .in_idx     (s_tdata[19:8]),
        .clr_busy   (clr_busy),
        .q_full     (q_full),
        .push       (q_push),
        .push_ctrl  (push_ctrl),
        .push_faddr (push_faddr),
        .push_laddr (push_laddr),
        .push_idx   (push_idx)
    );

    assign q_wdata = {push_ctrl, push_faddr, push_laddr, push_idx};

    nkc_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    assign head_ctrl = cmd_ctrl_t'(q_rdata[QW-1 -: CTRL_W]);

    nkc_back #(
        .MAX_ORDER  (MAX_ORDER),
        .COUNT_BITS (COUNT_BITS),
        .FW         (FW),
        .LA         (LA)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_ctrl    (head_ctrl),
        .q_faddr   (q_rdata[LA+IDX_W +: FW]),
        .q_laddr   (q_rdata[IDX_W +: LA]),
        .q_idx     (q_rdata[IDX_W-1:0]),
        .q_pop     (q_pop),
        .clr_busy  (clr_busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_idx   (out_idx),
        .out_count (out_count)
    );

    assign m_tdata = {(M_TDATA_W - COUNT_OUT_W - IDX_W)'(0), out_count, out_idx};

    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> (q_empty && !m_tvalid))
        else $error("traffic during the clearing pass");

    a_read_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == MODE_RD_FULL || s_tuser == MODE_RD_LOWER))
        |=> !q_empty)
        else $error("accepted read did not reach the queue");

endmodule

@@ dv/nucleotide_kmer_counter_tb.sv @@
// Self-checking testbench for nucleotide_kmer_counter: k-mer tallies are predicted
// in a small class and checked against every read result on the m stream.
// Depends on nkc_pkg and the nucleotide_kmer_counter RTL.
module nucleotide_kmer_counter_tb import nkc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ORD     = DEF_MAX_ORDER;
    localparam int FULL_DEPTH  = 1 << (2 * (MAX_ORD + 1));
    localparam int LOWER_DEPTH = 1 << (2 * MAX_ORD);
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 250;
    localparam int SETTLE      = 16;

    class kmer_tally;
        typedef struct {
            logic [IDX_W-1:0]       idx;
            logic [COUNT_OUT_W-1:0] count;
        } count_read_t;

        logic [COUNT_OUT_W-1:0] full_tally[FULL_DEPTH];
        logic [COUNT_OUT_W-1:0] lower_tally[LOWER_DEPTH];
        logic [IDX_W-1:0]       window;
        int unsigned            seen;
        logic [ORDER_W-1:0]     order;
        logic [IDX_W-1:0]       last_kmer;
        count_read_t            pending_reads[$];
        int                     bad_reads;

        function new();
            foreach (full_tally[i])
                full_tally[i] = '0;
            foreach (lower_tally[i])
                lower_tally[i] = '0;
            window    = '0;
            seen      = 0;
            order     = ORDER_RESET;
            last_kmer = '0;
            bad_reads = 0;
        endfunction

        function int unsigned eff_order();
            return (order > MAX_ORD) ? MAX_ORD : order;
        endfunction

        function logic [IDX_W-1:0] low_bases(logic [IDX_W-1:0] v, int unsigned n_bases);
            logic [31:0] mask;
            mask = (32'd1 << (2 * n_bases)) - 32'd1;
            return v & mask[IDX_W-1:0];
        endfunction

        function void take_item(mode_t m, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
            logic [1:0]       code;
            logic             is_base;
            logic [IDX_W-1:0] kmer;
            count_read_t      r;
            int unsigned      ord;
            ord     = eff_order();
            is_base = 1'b1;
            code    = BASE_A;
            case (m)
                MODE_BASE:
                begin
                    case (ch)
                        CHAR_A:  code = BASE_A;
                        CHAR_T:  code = BASE_T;
                        CHAR_C:  code = BASE_C;
                        CHAR_G:  code = BASE_G;
                        default: is_base = 1'b0;
                    endcase
                    if (is_base)
                    begin
                        window = {window[IDX_W-3:0], code};
                        if (seen < MAX_ORD + 1)
                            seen++;
                        if (seen >= ord + 1)
                        begin
                            kmer      = low_bases(window, ord + 1);
                            last_kmer = kmer;
                            if (full_tally[kmer] != '1)
                                full_tally[kmer] += 1;
                            if (lower_tally[kmer >> 2] != '1)
                                lower_tally[kmer >> 2] += 1;
                        end
                    end
                end
                MODE_EOR:
                begin
                    if (seen >= ord)
                    begin
                        kmer = low_bases(window, ord);
                        if (lower_tally[kmer] != '1)
                            lower_tally[kmer] += 1;
                    end
                    window = '0;
                    seen   = 0;
                end
                default:
                begin
                    r.idx   = idx;
                    r.count = '0;
                    if (m == MODE_RD_FULL)
                        r.count = full_tally[idx];
                    else if (idx < LOWER_DEPTH)
                        r.count = lower_tally[idx];
                    pending_reads.insert(pending_reads.size(), r);
                end
            endcase
        endfunction

        function void match_read(logic [IDX_W-1:0] idx, logic [COUNT_OUT_W-1:0] count);
            count_read_t r;
            if (pending_reads.size() == 0)
            begin
                bad_reads++;
                if (bad_reads <= 10)
                    $display("%0t: unexpected result, index %0d count %0d", $realtime, idx, count);
                return;
            end
            r = pending_reads.pop_front();
            if (idx !== r.idx || count !== r.count)
            begin
                bad_reads++;
                if (bad_reads <= 10)
                    $display("%0t: mismatch, index exp %0d got %0d, count exp %0d got %0d",
                             $realtime, r.idx, idx, r.count, count);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [ORDER_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [7:0] character, [19:8] table_index
    logic [MODE_W-1:0]    s_tuser;   // [1:0] mode
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [11:0] read_index, [43:12] count_value

    kmer_tally sb = new;
    logic      calm;
    logic      no_gaps;
    logic      hold_req;
    int        cycles;
    int        stall_left;

    nucleotide_kmer_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.match_read(m_tdata[IDX_W-1:0], m_tdata[IDX_W +: COUNT_OUT_W]);
    end

    // receiver: random stall bursts, plus one long hold on request
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                m_tready   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready   = 1'b0;
                stall_left = int'($urandom_range(1, 18)) - 1;
            end
            else
                m_tready = 1'b1;
        end
    end

    task automatic send_item(mode_t m, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
        @(negedge clk);
        if (!calm && !no_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = m;
        s_tdata  = S_TDATA_W'({idx, ch});
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_item(m, ch, idx);
    endtask

    function automatic logic [CHAR_W-1:0] rand_base();
        case ($urandom_range(0, 3))
            0:       return CHAR_A;
            1:       return CHAR_T;
            2:       return CHAR_C;
            default: return CHAR_G;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] rand_char();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [IDX_W-1:0] rand_any_index();
        return IDX_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [IDX_W-1:0] rand_index(logic full_tbl);
        int unsigned n;
        n = full_tbl ? sb.eff_order() + 1 : sb.eff_order();
        if ($urandom_range(0, 4) == 0)
            return rand_any_index();
        return sb.low_bases(rand_any_index(), n);
    endfunction

    task automatic send_read(logic full_tbl, logic [IDX_W-1:0] idx);
        send_item(full_tbl ? MODE_RD_FULL : MODE_RD_LOWER, rand_char(), idx);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending_reads.size() != 0)
            @(posedge clk);
        // base and end-of-record items may still be in the queue
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_order(logic [ORDER_W-1:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.order = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic squeeze();
        logic full_tbl;
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (40)
        begin
            full_tbl = 1'($urandom_range(0, 1));
            send_read(full_tbl, rand_index(full_tbl));
        end
        no_gaps = 1'b0;
    endtask

    task automatic run_phase(int n_items);
        int   sent;
        int   len;
        int   pick;
        logic full_tbl;
        sent = 0;
        while (sent < n_items)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 65)
            begin
                len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2))
                                                  : int'($urandom_range(1, 12));
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_item(MODE_BASE, rand_char(), rand_any_index());
                        sent++;
                    end
                    send_item(MODE_BASE, rand_base(), rand_any_index());
                    sent++;
                    // now and then read back the entry last bumped, as the next item after the base
                    if ($urandom_range(0, 9) == 0)
                    begin
                        full_tbl = 1'($urandom_range(0, 1));
                        send_read(full_tbl, full_tbl ? sb.last_kmer : sb.last_kmer >> 2);
                        sent++;
                    end
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    send_item(MODE_EOR, rand_char(), rand_any_index());
                    sent++;
                end
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    full_tbl = 1'($urandom_range(0, 1));
                    send_read(full_tbl, rand_index(full_tbl));
                    sent++;
                end
            end
            else
            begin
                send_item(mode_t'(MODE_W'($urandom_range(0, 1))), rand_char(),
                          rand_any_index());
                sent++;
            end
        end
    endtask

    initial
    begin
        int orders[9] = '{0, 7, 1, 5, 6, 3, 4, 0, 2};
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_BASE;
        calm      = 1'b0;
        no_gaps   = 1'b0;
        hold_req  = 1'b0;
        cycles    = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, at the reset order: ATC and TCG windows, skipped characters,
        // empty record, table edges and lower reads beyond its depth
        send_item(MODE_BASE, CHAR_A, 12'hfff);
        send_item(MODE_BASE, CHAR_T, 12'h000);
        send_item(MODE_BASE, 8'h61, 12'h000);
        send_item(MODE_BASE, 8'h00, 12'h000);
        send_item(MODE_BASE, 8'hff, 12'h000);
        send_item(MODE_BASE, CHAR_C, 12'h000);
        send_item(MODE_BASE, CHAR_G, 12'h000);
        send_item(MODE_BASE, 8'h4e, 12'h000);
        send_item(MODE_EOR, 8'hff, 12'hfff);
        send_item(MODE_EOR, 8'h00, 12'h000);
        send_read(1'b1, 12'd6);
        send_read(1'b1, 12'd27);
        send_read(1'b0, 12'd1);
        send_read(1'b0, 12'd6);
        send_read(1'b0, 12'd11);
        send_read(1'b1, 12'd0);
        send_read(1'b1, 12'd4095);
        send_read(1'b0, 12'd1023);
        send_read(1'b0, 12'd1024);
        send_read(1'b0, 12'd4095);
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 8)
                calm = 1'b1;
            write_order(ORDER_W'(orders[ph]));
            if (ph == 1)
                squeeze();
            run_phase(210);
            drain();
        end

        if (sb.bad_reads == 0 && sb.pending_reads.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
